/* rtl/lpfr_pkg.sv */
// package: types, constants and status codes of the length prefixed frame receiver
`default_nettype none
package lpfr_pkg;

    localparam int CHECKSUM_BITS = 32;
    localparam int EXPECT_BITS   = 32;
    localparam int CMP_BITS      = 64;
    localparam int LEN_BITS      = 24;
    localparam int BYTE_BITS     = 8;
    localparam int HDR_BYTES     = 4;

    localparam logic [LEN_BITS-1:0] MAX_LENGTH_RESET = 24'h10_0000;

    typedef logic [CHECKSUM_BITS-1:0] t_sum;
    typedef logic [EXPECT_BITS-1:0]   t_expect;
    typedef logic [CMP_BITS-1:0]      t_cmp;
    typedef logic [LEN_BITS-1:0]      t_len;
    typedef logic [BYTE_BITS-1:0]     t_byte;
    typedef logic [2:0]               t_hdr_count;

    localparam t_hdr_count HDR_FULL = t_hdr_count'(HDR_BYTES);
    localparam t_hdr_count HDR_LAST = t_hdr_count'(HDR_BYTES - 1);

    typedef enum logic [1:0] {
        ST_ACCEPT     = 2'd0,
        ST_GOOD       = 2'd1,
        ST_BAD_SUM    = 2'd2,
        ST_FORMAT_ERR = 2'd3
    } t_status;

    typedef struct packed {
        t_status status;
        logic    payload_valid;
        t_byte   payload_byte;
        t_len    payload_index;
        logic    frame_end;
        t_len    frame_length;
    } t_result;

endpackage
`default_nettype wire

/* rtl/lpfr_byte_if.sv */
// interface: input byte channel with valid/ready handshake
`default_nettype none
interface lpfr_byte_if;
    logic             valid;
    logic             ready;
    lpfr_pkg::t_byte  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/lpfr_result_if.sv */
// interface: result channel with valid/ready handshake
`default_nettype none
interface lpfr_result_if;
    logic              valid;
    logic              ready;
    lpfr_pkg::t_status status;
    logic              payload_valid;
    lpfr_pkg::t_byte   payload_byte;
    lpfr_pkg::t_len    payload_index;
    logic              frame_end;
    lpfr_pkg::t_len    frame_length;

    modport source (output valid, output status, output payload_valid, output payload_byte,
                    output payload_index, output frame_end, output frame_length,
                    input ready);
    modport sink   (input valid, input status, input payload_valid, input payload_byte,
                    input payload_index, input frame_end, input frame_length,
                    output ready);
endinterface
`default_nettype wire

/* rtl/lpfr_parser.sv */
// parser: frame state registers and the per-byte result logic
`default_nettype none
module lpfr_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire lpfr_pkg::t_byte   i_data_byte,
    input  wire lpfr_pkg::t_len    i_max_length,
    output lpfr_pkg::t_result      o_result
);

    lpfr_pkg::t_hdr_count r_header_count, n_header_count;
    lpfr_pkg::t_len       r_length_accum, n_length_accum;
    lpfr_pkg::t_len       r_payload_pos, n_payload_pos;
    lpfr_pkg::t_sum       r_running_sum, n_running_sum;
    lpfr_pkg::t_expect    r_expected_sum, n_expected_sum;

    logic [31:0]          len_next;
    logic                 pos_zero;
    logic                 in_header;
    logic                 in_first;
    logic                 in_payload;
    logic                 in_checksum;
    lpfr_pkg::t_expect    expect_next;
    lpfr_pkg::t_result    res;

    assign len_next    = {r_length_accum, i_data_byte};
    assign pos_zero    = (r_payload_pos == '0);
    assign in_header   = pos_zero && (r_header_count < lpfr_pkg::HDR_FULL);
    assign in_first    = (r_length_accum != '0) && pos_zero
                         && (r_header_count == lpfr_pkg::HDR_FULL);
    assign in_payload  = !pos_zero && (r_payload_pos < r_length_accum)
                         && (r_header_count == '0);
    assign in_checksum = !pos_zero && (r_payload_pos == r_length_accum)
                         && (r_header_count < lpfr_pkg::HDR_FULL);
    assign expect_next = {r_expected_sum[lpfr_pkg::EXPECT_BITS-9:0], i_data_byte};

    always_comb begin
        n_header_count = r_header_count;
        n_length_accum = r_length_accum;
        n_payload_pos  = r_payload_pos;
        n_running_sum  = r_running_sum;
        n_expected_sum = r_expected_sum;
        res            = '0;
        res.status     = lpfr_pkg::ST_ACCEPT;
        if (in_header) begin
            if (len_next > {8'd0, i_max_length}) begin
                res.status = lpfr_pkg::ST_FORMAT_ERR;
                n_header_count = '0;
                n_length_accum = '0;
                n_payload_pos  = '0;
                n_running_sum  = '0;
                n_expected_sum = '0;
            end else begin
                n_length_accum = len_next[lpfr_pkg::LEN_BITS-1:0];
                n_header_count = r_header_count + 3'd1;
            end
        end else if (in_first) begin
            if (r_length_accum > i_max_length) begin
                res.status = lpfr_pkg::ST_FORMAT_ERR;
                n_header_count = '0;
                n_length_accum = '0;
                n_payload_pos  = '0;
                n_running_sum  = '0;
                n_expected_sum = '0;
            end else begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_data_byte;
                n_payload_pos     = lpfr_pkg::t_len'(1);
                n_header_count    = '0;
                n_running_sum     = r_running_sum + lpfr_pkg::t_sum'(i_data_byte);
            end
        end else if (in_payload) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = i_data_byte;
            res.payload_index = r_payload_pos;
            n_payload_pos     = r_payload_pos + lpfr_pkg::t_len'(1);
            n_running_sum     = r_running_sum + lpfr_pkg::t_sum'(i_data_byte);
        end else if (in_checksum) begin
            n_expected_sum = expect_next;
            n_header_count = r_header_count + 3'd1;
            if (r_header_count == lpfr_pkg::HDR_LAST) begin
                res.frame_end    = 1'b1;
                res.frame_length = r_length_accum;
                res.status       = (lpfr_pkg::t_cmp'(expect_next)
                                    == lpfr_pkg::t_cmp'(r_running_sum))
                                   ? lpfr_pkg::ST_GOOD : lpfr_pkg::ST_BAD_SUM;
                n_header_count = '0;
                n_length_accum = '0;
                n_payload_pos  = '0;
                n_running_sum  = '0;
                n_expected_sum = '0;
            end
        end else begin
            res.status     = lpfr_pkg::ST_FORMAT_ERR;
            n_header_count = '0;
            n_length_accum = '0;
            n_payload_pos  = '0;
            n_running_sum  = '0;
            n_expected_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count <= '0;
            r_length_accum <= '0;
            r_payload_pos  <= '0;
            r_running_sum  <= '0;
            r_expected_sum <= '0;
        end else if (i_advance) begin
            r_header_count <= n_header_count;
            r_length_accum <= n_length_accum;
            r_payload_pos  <= n_payload_pos;
            r_running_sum  <= n_running_sum;
            r_expected_sum <= n_expected_sum;
        end
    end

    assign o_result = res;

endmodule
`default_nettype wire

/* rtl/length_prefixed_frame_receiver_unit.sv */
// top level: input register, frame parser, result register and limit register
`default_nettype none
// Deframes a byte stream of 4-byte big-endian length, payload, 4-byte big-endian
// additive checksum. Every accepted byte gives exactly one result through the input
// and result registers; one byte per clock is sustained while results are taken, as
// the parser's result logic is combinational between them. The input register keeps
// taking bytes while a result waits, and stalls only when both are full and the
// result is not taken. Payload bytes come out as they arrive; the frame-end result
// says whether the checksum matched, and a bad length gives a format error that
// restarts parsing. max_length may be written only while no request is in flight.
module length_prefixed_frame_receiver_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire lpfr_pkg::t_len   i_cfg_wdata,
    lpfr_byte_if.sink             i_in,
    lpfr_result_if.source         o_res
);

    logic               r_in_valid;
    lpfr_pkg::t_byte    r_in_byte;
    logic               r_out_valid;
    lpfr_pkg::t_result  r_res;
    lpfr_pkg::t_len     r_max_length;
    lpfr_pkg::t_result  parse_res;
    logic               out_free;
    logic               advance;

    assign out_free   = !r_out_valid || o_res.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    lpfr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_data_byte  (r_in_byte),
        .i_max_length (r_max_length),
        .o_result     (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= lpfr_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= parse_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_res.status;
    assign o_res.payload_valid = r_res.payload_valid;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.payload_index = r_res.payload_index;
    assign o_res.frame_end     = r_res.frame_end;
    assign o_res.frame_length  = r_res.frame_length;

`ifndef SYNTHESIS
    a_end_not_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.payload_valid && r_res.frame_end))
        else $error("frame end and payload byte in one result");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.frame_end == (r_res.status == lpfr_pkg::ST_GOOD
                                             || r_res.status == lpfr_pkg::ST_BAD_SUM)))
        else $error("frame end does not match status");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status == lpfr_pkg::ST_FORMAT_ERR)
            |-> (!r_res.payload_valid && r_res.frame_length == '0
                 && r_res.payload_index == '0))
        else $error("format error carries data");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("parsed byte lost before result register");
`endif

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: directed and random byte streams through the frame receiver, checked result by result
module testbench;
    import lpfr_pkg::*;

    typedef struct packed {
        t_hdr_count  hdr;
        logic [31:0] len;
        t_len        pos;
        t_sum        sum;
        t_expect     rcvd;
    } t_deframe_state;

    typedef struct packed {
        logic    is_cfg;
        logic    typed;
        t_len    value;
        t_result res;
    } t_script_row;

    localparam t_result NIL    = '0;
    localparam t_result FMT    = '{ST_FORMAT_ERR, 1'b0, 8'h00, 24'h0, 1'b0, 24'h0};
    localparam t_result PAY_FF = '{ST_ACCEPT, 1'b1, 8'hff, 24'h0, 1'b0, 24'h0};
    localparam t_result GOOD_1 = '{ST_GOOD, 1'b0, 8'h00, 24'h0, 1'b1, 24'h1};

    localparam int SCRIPT_ROWS = 28;
    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        // one-byte frame with a matching checksum
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h01, NIL},
        '{1'b0, 1'b1, 24'hff, PAY_FF},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b1, 24'hff, GOOD_1},
        // oversized length
        '{1'b0, 1'b0, 24'hff, NIL}, '{1'b0, 1'b0, 24'hff, NIL},
        '{1'b0, 1'b1, 24'hff, FMT},
        // zero length
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b1, 24'h55, FMT},
        // limit lowered after the header
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b0, 24'h02, NIL},
        '{1'b1, 1'b0, 24'h000001, NIL},
        '{1'b0, 1'b1, 24'haa, FMT},
        // largest limit, length beyond 24 bits
        '{1'b1, 1'b0, 24'hffffff, NIL},
        '{1'b0, 1'b0, 24'h01, NIL}, '{1'b0, 1'b0, 24'h00, NIL},
        '{1'b0, 1'b0, 24'h00, NIL}, '{1'b0, 1'b1, 24'h00, FMT}
    };

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    t_len cfg_wdata;
    logic result_ready = 1'b0;

    lpfr_byte_if   req_if ();
    lpfr_result_if res_if ();

    assign res_if.ready = result_ready;

    length_prefixed_frame_receiver_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_if),
        .o_res       (res_if)
    );

    t_result        expected_results [$];
    t_deframe_state sent_state;
    t_deframe_state seen_state;
    t_len           max_length;
    int             src_idle_pct;
    int             sink_idle_pct = 62;
    int             bytes_sent;
    int             error_count;

    function automatic t_result deframe_byte(inout t_deframe_state s, input t_len limit,
                                             input t_byte b);
        t_result     r;
        logic [39:0] grown;
        r = '0;
        grown = {s.len, b};
        if (s.pos == '0 && s.hdr < HDR_FULL) begin
            if (grown > {16'h0, limit}) begin
                s = '0;
                r.status = ST_FORMAT_ERR;
            end else begin
                s.len = grown[31:0];
                s.hdr = s.hdr + 1'b1;
            end
        end else if (s.len != '0 && s.pos == '0 && s.hdr == HDR_FULL) begin
            if (s.len > {8'h0, limit}) begin
                s = '0;
                r.status = ST_FORMAT_ERR;
            end else begin
                r.payload_valid = 1'b1;
                r.payload_byte = b;
                s.pos = t_len'(1);
                s.hdr = '0;
                s.sum = s.sum + t_sum'(b);
            end
        end else if (s.pos != '0 && {8'h0, s.pos} < s.len && s.hdr == '0) begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = s.pos;
            s.pos = s.pos + 1'b1;
            s.sum = s.sum + t_sum'(b);
        end else if (s.pos != '0 && {8'h0, s.pos} == s.len && s.hdr < HDR_FULL) begin
            s.rcvd = {s.rcvd[EXPECT_BITS-9:0], b};
            s.hdr = s.hdr + 1'b1;
            if (s.hdr == HDR_FULL) begin
                r.frame_end = 1'b1;
                r.frame_length = s.len[LEN_BITS-1:0];
                r.status = (s.rcvd == s.sum) ? ST_GOOD : ST_BAD_SUM;
                s = '0;
            end
        end else begin
            s = '0;
            r.status = ST_FORMAT_ERR;
        end
        return r;
    endfunction

    function automatic t_byte any_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return t_byte'($urandom_range(255));
        endcase
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_error("result arrived with no request outstanding");
        end else begin
            want = expected_results.pop_front();
            if (res_if.status != want.status)
                report_error($sformatf("status %0d, expected %0d", res_if.status, want.status));
            if (res_if.payload_valid != want.payload_valid)
                report_error($sformatf("payload_valid %0d, expected %0d",
                                       res_if.payload_valid, want.payload_valid));
            if (res_if.payload_byte != want.payload_byte)
                report_error($sformatf("payload_byte %0h, expected %0h",
                                       res_if.payload_byte, want.payload_byte));
            if (res_if.payload_index != want.payload_index)
                report_error($sformatf("payload_index %0d, expected %0d",
                                       res_if.payload_index, want.payload_index));
            if (res_if.frame_end != want.frame_end)
                report_error($sformatf("frame_end %0d, expected %0d",
                                       res_if.frame_end, want.frame_end));
            if (res_if.frame_length != want.frame_length)
                report_error($sformatf("frame_length %0d, expected %0d",
                                       res_if.frame_length, want.frame_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && result_ready)
            check_result();
        result_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // sent_state follows the stream as it is generated, seen_state as requests are taken
    task automatic drive_byte(input t_byte b, input logic typed, input t_result typed_res,
                              output logic broke);
        t_result shadow;
        t_result predicted;
        shadow = deframe_byte(sent_state, max_length, b);
        broke = (shadow.status == ST_FORMAT_ERR);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data_byte <= b;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = deframe_byte(seen_state, max_length, b);
        expected_results.push_back(typed ? typed_res : predicted);
        bytes_sent++;
    endtask

    task automatic write_max_length(input t_len v);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        max_length = v;
    endtask

    task automatic send_sequence(input t_byte seq [$], input int keep);
        logic broke;
        broke = 1'b0;
        for (int i = 0; i < keep && !broke; i++)
            drive_byte(seq[i], 1'b0, NIL, broke);
        // a cut frame is finished with noise until the parser is back at a frame start
        while (sent_state != '0)
            drive_byte(any_byte(), 1'b0, NIL, broke);
    endtask

    task automatic run_random(input int stop_at);
        t_byte seq [$];
        t_byte b;
        t_sum  sum;
        int    n;
        int    pick;
        int    keep;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick >= 70 && pick < 80) begin
                seq = {t_byte'($urandom_range(1, 255)), any_byte(), any_byte(), any_byte()};
                keep = 4;
            end else if (pick >= 80 && pick < 88) begin
                seq = {8'h00, 8'h00, 8'h00, 8'h00, any_byte()};
                keep = 5;
            end else begin
                n = ($urandom_range(15) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 24);
                seq = {t_byte'(n >> 24), t_byte'(n >> 16), t_byte'(n >> 8), t_byte'(n)};
                sum = '0;
                for (int i = 0; i < n; i++) begin
                    b = any_byte();
                    sum = sum + t_sum'(b);
                    seq.push_back(b);
                end
                if ($urandom_range(9) == 0)
                    sum = sum ^ t_sum'($urandom() | 1);
                for (int k = 3; k >= 0; k--)
                    seq.push_back(t_byte'(sum >> (8 * k)));
                keep = (pick >= 88) ? $urandom_range(4, seq.size() - 1) : seq.size();
            end
            send_sequence(seq, keep);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_200_000;
        $display("length_prefixed_frame_receiver_unit regression: fail");
        $finish;
    end

    initial begin
        t_script_row row;
        logic        broke;
        t_len        limits [6];
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.data_byte <= '0;
        src_idle_pct = 23;
        max_length = MAX_LENGTH_RESET;
        sent_state = '0;
        seen_state = '0;
        bytes_sent = 0;
        error_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            row = SCRIPT[i];
            if (row.is_cfg)
                write_max_length(row.value);
            else
                drive_byte(row.value[7:0], row.typed, row.res, broke);
        end

        limits = '{24'hffffff, 24'd20, 24'd0, t_len'($urandom_range(1, 64)),
                   MAX_LENGTH_RESET, 24'd600};
        for (int seg = 0; seg < 6; seg++) begin
            write_max_length(limits[seg]);
            src_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 62 : 0;
            sink_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 23 : 0;
            run_random(bytes_sent + 317);
        end

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (error_count == 0)
            $display("length_prefixed_frame_receiver_unit regression: pass");
        else
            $display("length_prefixed_frame_receiver_unit regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/lpfr_pkg.sv
rtl/lpfr_byte_if.sv
rtl/lpfr_result_if.sv
rtl/lpfr_parser.sv
rtl/length_prefixed_frame_receiver_unit.sv
tb/sv/testbench.sv
